// ----- hw/rtl/ebalu_pkg.sv -----
// Package with the command codes, operand sources and flag type of the eight-bit ALU.
package ebalu_pkg;

    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = 3;
    localparam logic [3:0] NIBBLE_MAX = 4'hF;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_ADC  = 4'd1,
        CMD_SBC  = 4'd2,
        CMD_AND  = 4'd3,
        CMD_OR   = 4'd4,
        CMD_CP   = 4'd5,
        CMD_INC  = 4'd6,
        CMD_DEC  = 4'd7,
        CMD_LOAD = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        SRC_REG = 2'd0,
        SRC_MEM = 2'd1,
        SRC_IMM = 2'd2
    } src_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

// ----- hw/rtl/eight_bit_alu_with_flags.sv -----
// Top level of the eight-bit ALU: input register, ALU, register file, flags and result register.
//
//   channel  direction  payload                                         handshake
//   s_       in         command, operand_source, reg_index, operand_byte s_valid / s_ready
//   m_       out        result_byte, memory_write, accumulator, flags    m_valid / m_ready
//
// One instruction per cycle while the result is not stalled; an accepted instruction passes
// through the input register and then the result register, from which its result is transferred.
// The ALU between the input register and the result register updates the register file
// and the flags at the same edge, so the next instruction sees them without delay.
// Reset clears the register file, the flags and both valid bits.
// A stalled result holds the pipeline; s_ready falls only when both stages are full
// and m_ready is low.
module eight_bit_alu_with_flags (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_command,
    input  logic [1:0] s_operand_source,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_operand_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_byte,
    output logic       m_memory_write,
    output logic [7:0] m_accumulator,
    output logic       m_zero_flag,
    output logic       m_subtract_flag,
    output logic       m_half_carry_flag,
    output logic       m_carry_flag
);

    logic                           in_valid_reg;
    logic [3:0]                     cmd_reg;
    logic [1:0]                     src_reg;
    logic [ebalu_pkg::REG_IDX_W-1:0] idx_reg;
    logic [7:0]                     imm_reg;

    logic [7:0]        rf_reg   [ebalu_pkg::REG_COUNT];
    logic [7:0]        rf_next  [ebalu_pkg::REG_COUNT];
    ebalu_pkg::flags_t flag_reg;
    ebalu_pkg::flags_t flag_next;

    logic       out_valid_reg;
    logic [7:0] res_reg;
    logic       mw_reg;
    logic [7:0] res_next;
    logic       mw_next;

    logic       advance;
    logic       idx_ok;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic [7:0] incdec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign idx_ok = idx_reg < ebalu_pkg::REG_IDX_W'(ebalu_pkg::REG_COUNT);
    assign acc    = rf_reg[0];
    assign opnd   = (src_reg == ebalu_pkg::SRC_REG) ? (idx_ok ? rf_reg[idx_reg] : 8'h00)
                                                    : imm_reg;
    assign cin    = (cmd_reg == ebalu_pkg::CMD_ADC || cmd_reg == ebalu_pkg::CMD_SBC)
                    ? flag_reg.c : 1'b0;
    assign sum9   = {1'b0, acc} + {1'b0, opnd} + {8'h00, cin};
    assign sum5   = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'h0, cin};
    assign dif9   = {1'b0, acc} - {1'b0, opnd} - {8'h00, cin};
    assign dif5   = {1'b0, acc[3:0]} - {1'b0, opnd[3:0]} - {4'h0, cin};
    assign incdec = (cmd_reg == ebalu_pkg::CMD_INC) ? opnd + 8'h01 : opnd - 8'h01;

    always_comb begin
        rf_next   = rf_reg;
        flag_next = flag_reg;
        res_next  = 8'h00;
        mw_next   = 1'b0;
        case (cmd_reg)
            ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
                res_next   = sum9[7:0];
                flag_next  = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: sum5[4], c: sum9[8]};
                rf_next[0] = sum9[7:0];
            end
            ebalu_pkg::CMD_SBC, ebalu_pkg::CMD_CP: begin
                res_next  = dif9[7:0];
                flag_next = '{z: (dif9[7:0] == 8'h00), n: 1'b1, h: dif5[4], c: dif9[8]};
                if (cmd_reg == ebalu_pkg::CMD_SBC) begin
                    rf_next[0] = dif9[7:0];
                end
            end
            ebalu_pkg::CMD_AND: begin
                res_next   = acc & opnd;
                flag_next  = '{z: ((acc & opnd) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
                rf_next[0] = acc & opnd;
            end
            ebalu_pkg::CMD_OR: begin
                res_next   = acc | opnd;
                flag_next  = '{z: ((acc | opnd) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
                rf_next[0] = acc | opnd;
            end
            ebalu_pkg::CMD_INC, ebalu_pkg::CMD_DEC: begin
                res_next = incdec;
                if (cmd_reg == ebalu_pkg::CMD_INC) begin
                    flag_next = '{z: (incdec == 8'h00), n: 1'b0,
                                  h: (opnd[3:0] == ebalu_pkg::NIBBLE_MAX), c: flag_reg.c};
                end else begin
                    flag_next = '{z: (incdec == 8'h00), n: 1'b1,
                                  h: (opnd[3:0] == 4'h0), c: flag_reg.c};
                end
                if (src_reg == ebalu_pkg::SRC_REG) begin
                    if (idx_ok) begin
                        rf_next[idx_reg] = incdec;
                    end
                end else if (src_reg == ebalu_pkg::SRC_MEM) begin
                    mw_next = 1'b1;
                end
            end
            ebalu_pkg::CMD_LOAD: begin
                res_next = imm_reg;
                if (idx_ok) begin
                    rf_next[idx_reg] = imm_reg;
                end
            end
            default: begin
                res_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
            for (int i = 0; i < ebalu_pkg::REG_COUNT; i++) begin
                rf_reg[i] <= 8'h00;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flag_reg      <= flag_next;
                rf_reg        <= rf_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg <= s_command;
            src_reg <= s_operand_source;
            idx_reg <= s_reg_index;
            imm_reg <= s_operand_byte;
        end
        if (advance) begin
            res_reg <= res_next;
            mw_reg  <= mw_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_byte     = res_reg;
    assign m_memory_write    = mw_reg;
    assign m_accumulator     = rf_reg[0];
    assign m_zero_flag       = flag_reg.z;
    assign m_subtract_flag   = flag_reg.n;
    assign m_half_carry_flag = flag_reg.h;
    assign m_carry_flag      = flag_reg.c;

`ifndef SYNTH
    a_state_holds: assert property (@(posedge aclk)
        (aresetn && !advance) |=> ($stable(flag_reg) && $stable(rf_reg[0])))
        else $error("State changed without an instruction executing.");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Executed instruction did not reach the result register.");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg) && $stable(imm_reg)))
        else $error("Stalled instruction was lost from the input register.");
`endif

endmodule
